// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the transposition table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Sampled on clk, switched off while rst is high.
`define DTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Sampled on clk, also checked while rst is high.
`define DTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg
// Types and constants shared by the transposition table modules.
// ----------------------------------------------------------------------------
package dtt_pkg;

  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] BOUND_EXACT = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;
  localparam logic [1:0] BOUND_UPPER = 2'd3;

  localparam logic signed [15:0] MATE_LIMIT = 16'sd29000;
  localparam logic [7:0]         DEPTH_MAX  = 8'd127;

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         flags;
    logic [3:0]         promo;
    logic [5:0]         target;
    logic [5:0]         source;
    logic signed [15:0] score;
    logic signed [7:0]  depth;
    logic [1:0]         bound;
    logic [5:0]         age;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    key:    64'd0,
    flags:  8'd0,
    promo:  4'd0,
    target: 6'd0,
    source: 6'd0,
    score:  16'sd0,
    depth:  -8'sd1,
    bound:  2'd0,
    age:    6'd0
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        position_key;
    logic [7:0]         search_depth;
    logic [6:0]         ply_from_root;
    logic signed [15:0] window_low;
    logic signed [15:0] window_high;
    logic signed [15:0] store_score;
    logic [1:0]         bound_kind;
    logic [5:0]         move_source;
    logic [5:0]         move_target;
    logic [3:0]         move_promo;
    logic [7:0]         move_flag_bits;
  } item_t;

  typedef struct packed {
    logic               key_match;
    logic               cutoff_hit;
    logic signed [15:0] found_score;
    logic [5:0]         found_source;
    logic [5:0]         found_target;
    logic [3:0]         found_promo;
    logic [7:0]         found_flags;
  } result_t;

  typedef struct packed {
    logic load;
    logic mem_rd;
    logic store_wr;
    logic out_load;
    logic sweep_wr;
    logic age_clear;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/dtt_if.sv =====
// ----------------------------------------------------------------------------
// dtt_if
// Request and response channels of the transposition table.
// ----------------------------------------------------------------------------
interface dtt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [63:0]        position_key;
  logic [7:0]         search_depth;
  logic [6:0]         ply_from_root;
  logic signed [15:0] window_low;
  logic signed [15:0] window_high;
  logic signed [15:0] store_score;
  logic [1:0]         bound_kind;
  logic [5:0]         move_source;
  logic [5:0]         move_target;
  logic [3:0]         move_promo;
  logic [7:0]         move_flag_bits;

  modport source (
    output valid, mode, position_key, search_depth, ply_from_root, window_low,
           window_high, store_score, bound_kind, move_source, move_target,
           move_promo, move_flag_bits,
    input  ready
  );
  modport sink (
    input  valid, mode, position_key, search_depth, ply_from_root, window_low,
           window_high, store_score, bound_kind, move_source, move_target,
           move_promo, move_flag_bits,
    output ready
  );
endinterface

interface dtt_rsp_if;
  logic               valid;
  logic               ready;
  logic               key_match;
  logic               cutoff_hit;
  logic signed [15:0] found_score;
  logic [5:0]         found_source;
  logic [5:0]         found_target;
  logic [3:0]         found_promo;
  logic [7:0]         found_flags;

  modport source (
    output valid, key_match, cutoff_hit, found_score, found_source,
           found_target, found_promo, found_flags,
    input  ready
  );
  modport sink (
    input  valid, key_match, cutoff_hit, found_score, found_source,
           found_target, found_promo, found_flags,
    output ready
  );
endinterface

// ===== rtl/core/dtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: clearing sweep, item acceptance, table read, and update or output load steps.
// ----------------------------------------------------------------------------
module dtt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_mode,
  output logic          req_ready,
  input  dtt_pkg::sts_t sts,
  output dtt_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL} state_t;

  state_t state, state_next;
  logic   probe_op;

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = (state == S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          case (req_mode)
            dtt_pkg::MODE_PROBE, dtt_pkg::MODE_STORE: begin
              state_next = S_READ;
            end
            dtt_pkg::MODE_CLEAR: begin
              cmd.age_clear = 1'b1;
              state_next    = S_CLEAR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        // A probe waits here until the output register can take its result.
        if (probe_op) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.store_wr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      probe_op <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        probe_op <= (req_mode == dtt_pkg::MODE_PROBE);
      end
    end
  end

endmodule

// ===== rtl/core/dtt_datapath.sv =====
// ----------------------------------------------------------------------------
// dtt_datapath
// Entry memory, item and age registers, store and probe arithmetic, and the
// output register.
// ----------------------------------------------------------------------------
module dtt_datapath #(
  parameter int unsigned TABLE_ENTRIES
) (
  input  logic             clk,
  input  logic             rst,
  input  dtt_pkg::cmd_t    cmd,
  output dtt_pkg::sts_t    sts,
  input  logic             cfg_we,
  input  logic [5:0]       cfg_data,
  input  dtt_pkg::item_t   item,
  output logic             out_valid,
  input  logic             out_ready,
  output dtt_pkg::result_t result
);

  localparam int unsigned    IDX_W    = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);

  dtt_pkg::entry_t  mem [TABLE_ENTRIES];
  dtt_pkg::entry_t  rd_q;
  dtt_pkg::item_t   item_q;
  dtt_pkg::result_t result_next;
  dtt_pkg::entry_t  new_entry;
  dtt_pkg::entry_t  mem_wdata;

  logic [5:0]       age;
  logic [IDX_W-1:0] sweep_cnt;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] mem_addr;
  logic             mem_we;
  logic             replace;

  logic signed [8:0]  req_depth9;
  logic signed [8:0]  slot_depth9;
  logic signed [16:0] store_wide;
  logic signed [16:0] ply17;
  logic signed [16:0] store_adj;
  logic signed [15:0] store_sat;
  logic signed [15:0] ply16;
  logic signed [15:0] probe_adj;
  logic               probe_hit;

  assign idx         = item_q.position_key[IDX_W-1:0] & IDX_MASK;
  assign req_depth9  = $signed({1'b0, item_q.search_depth});
  assign slot_depth9 = $signed({rd_q.depth[7], rd_q.depth});
  assign ply17       = $signed({10'd0, item_q.ply_from_root});
  assign ply16       = $signed({9'd0, item_q.ply_from_root});
  assign store_wide  = $signed({item_q.store_score[15], item_q.store_score});

  assign sts.sweep_last = (sweep_cnt == IDX_MASK);
  assign sts.out_free   = !out_valid || out_ready;

  // Store: mate scores move away from zero by the ply, then saturate.
  always_comb begin
    if (item_q.store_score > dtt_pkg::MATE_LIMIT) begin
      store_adj = store_wide + ply17;
    end else if (item_q.store_score < -dtt_pkg::MATE_LIMIT) begin
      store_adj = store_wide - ply17;
    end else begin
      store_adj = store_wide;
    end
    if (store_adj > 17'sd32767) begin
      store_sat = 16'sh7FFF;
    end else if (store_adj < -17'sd32768) begin
      store_sat = 16'sh8000;
    end else begin
      store_sat = store_adj[15:0];
    end
  end

  always_comb begin
    replace = (rd_q.key != item_q.position_key) || (req_depth9 >= slot_depth9) ||
              (rd_q.age != age);
    new_entry.key    = item_q.position_key;
    new_entry.flags  = item_q.move_flag_bits;
    new_entry.promo  = item_q.move_promo;
    new_entry.target = item_q.move_target;
    new_entry.source = item_q.move_source;
    new_entry.score  = store_sat;
    new_entry.depth  = (item_q.search_depth > dtt_pkg::DEPTH_MAX) ?
                       $signed(dtt_pkg::DEPTH_MAX) : $signed(item_q.search_depth);
    new_entry.bound  = item_q.bound_kind;
    new_entry.age    = age;
  end

  // Probe: undo the mate adjustment for this ply and test the bound.
  always_comb begin
    if (rd_q.score > dtt_pkg::MATE_LIMIT) begin
      probe_adj = rd_q.score - ply16;
    end else if (rd_q.score < -dtt_pkg::MATE_LIMIT) begin
      probe_adj = rd_q.score + ply16;
    end else begin
      probe_adj = rd_q.score;
    end
    case (rd_q.bound)
      dtt_pkg::BOUND_EXACT: probe_hit = 1'b1;
      dtt_pkg::BOUND_LOWER: probe_hit = (probe_adj >= item_q.window_high);
      dtt_pkg::BOUND_UPPER: probe_hit = (probe_adj <= item_q.window_low);
      default:              probe_hit = 1'b0;
    endcase
    result_next = '0;
    if (rd_q.key == item_q.position_key) begin
      result_next.key_match    = 1'b1;
      result_next.found_source = rd_q.source;
      result_next.found_target = rd_q.target;
      result_next.found_promo  = rd_q.promo;
      result_next.found_flags  = rd_q.flags;
      if (!(slot_depth9 < req_depth9)) begin
        result_next.cutoff_hit  = probe_hit;
        result_next.found_score = probe_adj;
      end
    end
  end

  assign mem_we    = cmd.sweep_wr || (cmd.store_wr && replace);
  assign mem_addr  = cmd.sweep_wr ? sweep_cnt : idx;
  assign mem_wdata = cmd.sweep_wr ? dtt_pkg::ENTRY_RESET : new_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age       <= 6'd0;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.age_clear) begin
        age <= 6'd0;
      end else if (cfg_we) begin
        age <= cfg_data;
      end
      if (cmd.sweep_wr) begin
        sweep_cnt <= sts.sweep_last ? '0 : sweep_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q <= item;
    end
    if (cmd.out_load) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/core/depth_aged_transposition_table.sv =====
// ----------------------------------------------------------------------------
// depth_aged_transposition_table
// Direct-mapped transposition table with depth and age replacement, mate
// score ply adjustment and bound-based cutoff test on probes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req      in         probe, store or clear item
//  rsp      out        probe result (one per probe, none otherwise)
//  cfg      in         search_age write, no read-back
//
//  A probe or store steps from acceptance to the next req.ready as follows:
//  latch the item, perform the registered memory read, then update the
//  entry or load the output register. A probe waits in its last step while
//  rsp holds an untaken result. After reset and after a clear item the
//  memory is swept one entry a cycle, with req.ready low.
// ----------------------------------------------------------------------------
module depth_aged_transposition_table #(
  parameter int unsigned TABLE_ENTRIES = 4096
) (
  input  logic       clk,
  input  logic       rst,
  dtt_req_if.sink    req,
  dtt_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data
);

  dtt_pkg::cmd_t    cmd;
  dtt_pkg::sts_t    sts;
  dtt_pkg::item_t   item;
  dtt_pkg::result_t result;

  assign item.mode           = req.mode;
  assign item.position_key   = req.position_key;
  assign item.search_depth   = req.search_depth;
  assign item.ply_from_root  = req.ply_from_root;
  assign item.window_low     = req.window_low;
  assign item.window_high    = req.window_high;
  assign item.store_score    = req.store_score;
  assign item.bound_kind     = req.bound_kind;
  assign item.move_source    = req.move_source;
  assign item.move_target    = req.move_target;
  assign item.move_promo     = req.move_promo;
  assign item.move_flag_bits = req.move_flag_bits;

  assign rsp.key_match    = result.key_match;
  assign rsp.cutoff_hit   = result.cutoff_hit;
  assign rsp.found_score  = result.found_score;
  assign rsp.found_source = result.found_source;
  assign rsp.found_target = result.found_target;
  assign rsp.found_promo  = result.found_promo;
  assign rsp.found_flags  = result.found_flags;

  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_mode  (req.mode),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .item      (item),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result    (result)
  );

endmodule

// ===== rtl/core/dtt_checker.sv =====
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks for the transposition table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtt_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic [1:0]         req_mode,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               rsp_key_match,
  input logic               rsp_cutoff_hit,
  input logic signed [15:0] rsp_found_score,
  input logic [5:0]         rsp_found_source,
  input logic [5:0]         rsp_found_target,
  input logic [3:0]         rsp_found_promo,
  input logic [7:0]         rsp_found_flags
);

  // Reset starts the clearing sweep, so no item is taken right after it.
  `DTT_ASSERT_ALWAYS(a_reset_sweep, rst |=> !req_ready, "item accepted during reset sweep")

  // A probe, store or clear occupies the block for at least the next cycle.
  `DTT_ASSERT(a_busy_after_item, req_valid && req_ready && (req_mode == dtt_pkg::MODE_PROBE || req_mode == dtt_pkg::MODE_STORE || req_mode == dtt_pkg::MODE_CLEAR) |=> !req_ready, "ready right after a working item")

  // A miss reports nothing beyond the miss itself.
  `DTT_ASSERT(a_miss_zero, rsp_valid && !rsp_key_match |-> !rsp_cutoff_hit && rsp_found_score == 16'sd0 && rsp_found_source == 6'd0 && rsp_found_target == 6'd0 && rsp_found_promo == 4'd0 && rsp_found_flags == 8'd0, "miss with nonzero fields")

  `DTT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_score) && $stable(rsp_key_match), "stalled result changed")

endmodule

bind depth_aged_transposition_table dtt_checker u_dtt_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_mode         (req.mode),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_key_match    (rsp.key_match),
  .rsp_cutoff_hit   (rsp.cutoff_hit),
  .rsp_found_score  (rsp.found_score),
  .rsp_found_source (rsp.found_source),
  .rsp_found_target (rsp.found_target),
  .rsp_found_promo  (rsp.found_promo),
  .rsp_found_flags  (rsp.found_flags)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives probe, store and clear items into the transposition table, predicts
// every probe result from a cycle-free model of the table, and compares each
// result field by field. Both channels stall at random in two mixes, and then
// run without stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES        = 4096;
  localparam int          IDX_W          = 12;
  localparam logic [1:0]  MODE_IGNORED   = 2'd3;
  localparam logic [1:0]  BOUND_NONE     = 2'd0;
  localparam int          MATE_EDGE      = dtt_pkg::MATE_LIMIT;
  localparam int          DEPTH_CAP      = int'(dtt_pkg::DEPTH_MAX);
  localparam int          OP_CYCLES      = 8;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          MAX_REPORTS    = 40;
  localparam int          KEY_POOL       = 24;
  localparam int          AGE_PERIOD     = 60;

  typedef struct {
    logic [63:0] key;
    logic [5:0]  source;
    logic [5:0]  target;
    logic [3:0]  promo;
    logic [7:0]  flags;
    int          score;
    int          depth;
    logic [1:0]  bound;
    logic [5:0]  age;
  } tt_slot_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       cfg_we   = 1'b0;
  logic [5:0] cfg_data = 6'd0;

  dtt_req_if req_ch ();
  dtt_rsp_if rsp_ch ();

  depth_aged_transposition_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  tt_slot_t          tt_slots [ENTRIES];
  logic [5:0]        age_model;
  dtt_pkg::result_t  probe_results_q [$];
  logic [63:0]       key_pool [KEY_POOL];

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int idle_cycles;
  int results_checked;
  int n_probes, n_stores, n_clears, n_ignored, n_matches, n_hits, n_age_writes;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      tt_slots[i] = '{key: 64'd0, source: 6'd0, target: 6'd0, promo: 4'd0,
                      flags: 8'd0, score: 0, depth: -1, bound: BOUND_NONE,
                      age: 6'd0};
    end
    age_model = 6'd0;
  endfunction

  // Updates the table copy for one accepted item; returns 1 when the item
  // yields a probe result, which is then placed in res.
  function automatic bit apply_item(input dtt_pkg::item_t it,
                                    output dtt_pkg::result_t res);
    logic [IDX_W-1:0] idx;
    int               depth;
    int               ply;
    int               alpha;
    int               beta;
    int               score;
    tt_slot_t         s;
    idx   = it.position_key[IDX_W-1:0];
    depth = int'(it.search_depth);
    ply   = int'(it.ply_from_root);
    alpha = it.window_low;
    beta  = it.window_high;
    res   = '0;
    s     = tt_slots[idx];
    case (it.mode)
      dtt_pkg::MODE_CLEAR: begin
        clear_table();
        return 1'b0;
      end
      dtt_pkg::MODE_STORE: begin
        if (s.key == it.position_key && depth < s.depth && s.age == age_model) begin
          return 1'b0;
        end
        score = it.store_score;
        if (score > MATE_EDGE) score += ply;
        else if (score < -MATE_EDGE) score -= ply;
        if (score > 32767) score = 32767;
        if (score < -32768) score = -32768;
        s.key    = it.position_key;
        s.source = it.move_source;
        s.target = it.move_target;
        s.promo  = it.move_promo;
        s.flags  = it.move_flag_bits;
        s.score  = score;
        s.depth  = (depth > DEPTH_CAP) ? DEPTH_CAP : depth;
        s.bound  = it.bound_kind;
        s.age    = age_model;
        tt_slots[idx] = s;
        return 1'b0;
      end
      dtt_pkg::MODE_PROBE: begin
        if (s.key != it.position_key) return 1'b1;
        res.key_match    = 1'b1;
        res.found_source = s.source;
        res.found_target = s.target;
        res.found_promo  = s.promo;
        res.found_flags  = s.flags;
        if (s.depth < depth) return 1'b1;
        score = s.score;
        if (score > MATE_EDGE) score -= ply;
        else if (score < -MATE_EDGE) score += ply;
        case (s.bound)
          dtt_pkg::BOUND_EXACT: res.cutoff_hit = 1'b1;
          dtt_pkg::BOUND_LOWER: res.cutoff_hit = (score >= beta);
          dtt_pkg::BOUND_UPPER: res.cutoff_hit = (score <= alpha);
          default:              res.cutoff_hit = 1'b0;
        endcase
        res.found_score = score[15:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic dtt_pkg::item_t make_item(input logic [1:0] mode,
                                               input logic [63:0] key,
                                               input logic [7:0] depth,
                                               input logic [6:0] ply,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi,
                                               input logic signed [15:0] score,
                                               input logic [1:0] bound,
                                               input logic [23:0] move);
    dtt_pkg::item_t it;
    it.mode           = mode;
    it.position_key   = key;
    it.search_depth   = depth;
    it.ply_from_root  = ply;
    it.window_low     = lo;
    it.window_high    = hi;
    it.store_score    = score;
    it.bound_kind     = bound;
    it.move_flag_bits = move[23:16];
    it.move_promo     = move[15:12];
    it.move_target    = move[11:6];
    it.move_source    = move[5:0];
    return it;
  endfunction

  // Presents one item and returns at the edge where it is accepted, with
  // valid still high so that the next item can follow without a gap.
  task automatic send_item(input dtt_pkg::item_t it);
    dtt_pkg::result_t res;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_ch.valid          <= 1'b1;
    req_ch.mode           <= it.mode;
    req_ch.position_key   <= it.position_key;
    req_ch.search_depth   <= it.search_depth;
    req_ch.ply_from_root  <= it.ply_from_root;
    req_ch.window_low     <= it.window_low;
    req_ch.window_high    <= it.window_high;
    req_ch.store_score    <= it.store_score;
    req_ch.bound_kind     <= it.bound_kind;
    req_ch.move_source    <= it.move_source;
    req_ch.move_target    <= it.move_target;
    req_ch.move_promo     <= it.move_promo;
    req_ch.move_flag_bits <= it.move_flag_bits;
    do @(posedge clk); while (!req_ch.ready);
    if (apply_item(it, res)) begin
      probe_results_q.push_back(res);
      n_matches += res.key_match;
      n_hits    += res.cutoff_hit;
    end
    case (it.mode)
      dtt_pkg::MODE_PROBE: n_probes++;
      dtt_pkg::MODE_STORE: n_stores++;
      dtt_pkg::MODE_CLEAR: n_clears++;
      default:             n_ignored++;
    endcase
  endtask

  task automatic probe_entry(input logic [63:0] key, input logic [7:0] depth,
                             input logic [6:0] ply, input logic signed [15:0] lo,
                             input logic signed [15:0] hi);
    send_item(make_item(dtt_pkg::MODE_PROBE, key, depth, ply, lo, hi, 16'sd0,
                        BOUND_NONE, 24'd0));
  endtask

  task automatic store_entry(input logic [63:0] key, input logic [7:0] depth,
                             input logic [6:0] ply, input logic signed [15:0] score,
                             input logic [1:0] bound, input logic [23:0] move);
    send_item(make_item(dtt_pkg::MODE_STORE, key, depth, ply, 16'sd0, 16'sd0, score,
                        bound, move));
  endtask

  // Stores give no result, so a further OP_CYCLES wait follows the last
  // probe result; ready also stays low through a clearing sweep.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (probe_results_q.size() != 0) @(posedge clk);
    repeat (OP_CYCLES) @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_age(input logic [5:0] age);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= age;
    @(posedge clk);
    cfg_we    <= 1'b0;
    age_model  = age;
    n_age_writes++;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input longint got, input longint want);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH result %0d %s: got %0d, want %0d", results_checked, field, got, want);
    end
  endtask

  always @(posedge clk) begin
    dtt_pkg::result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (probe_results_q.size() == 0) begin
        report_mismatch("result with no probe waiting", 1, 0);
      end else begin
        want = probe_results_q.pop_front();
        if (rsp_ch.key_match !== want.key_match)
          report_mismatch("key_match", rsp_ch.key_match, want.key_match);
        if (rsp_ch.cutoff_hit !== want.cutoff_hit)
          report_mismatch("cutoff_hit", rsp_ch.cutoff_hit, want.cutoff_hit);
        if (rsp_ch.found_score !== want.found_score)
          report_mismatch("found_score", rsp_ch.found_score, want.found_score);
        if (rsp_ch.found_source !== want.found_source)
          report_mismatch("found_source", rsp_ch.found_source, want.found_source);
        if (rsp_ch.found_target !== want.found_target)
          report_mismatch("found_target", rsp_ch.found_target, want.found_target);
        if (rsp_ch.found_promo !== want.found_promo)
          report_mismatch("found_promo", rsp_ch.found_promo, want.found_promo);
        if (rsp_ch.found_flags !== want.found_flags)
          report_mismatch("found_flags", rsp_ch.found_flags, want.found_flags);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_entries();
    write_age(6'd5);
    // Key zero matches an untouched entry at index zero but never has depth.
    probe_entry(64'd0, 8'd0, 7'd0, -32768, 32767);
    probe_entry(64'h1000, 8'd0, 7'd0, 0, 0);
    probe_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 7'd127, 32767, -32768);
  endtask

  task automatic test_mate_and_saturation();
    store_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 7'd127, 32767, dtt_pkg::BOUND_EXACT,
                24'hFFFFFF);
    probe_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'd127, 7'd127, -32768, 32767);
    probe_entry(64'hFFFF_FFFF_FFFF_FFFF, 8'd128, 7'd0, 0, 0);
    store_entry(64'hA5A5_0000_0000_0001, 8'd10, 7'd127, -32768, dtt_pkg::BOUND_LOWER,
                {8'd4, 4'd3, 6'd2, 6'd1});
    probe_entry(64'hA5A5_0000_0000_0001, 8'd10, 7'd0, 0, -32768);
    store_entry(64'h5A5A_0000_0000_0002, 8'd3, 7'd100, 29001, dtt_pkg::BOUND_UPPER,
                {8'h81, 4'd9, 6'd33, 6'd12});
    probe_entry(64'h5A5A_0000_0000_0002, 8'd3, 7'd50, 29051, 0);
    store_entry(64'h3C3C_0000_0000_0005, 8'd2, 7'd40, 29000, dtt_pkg::BOUND_EXACT,
                24'h123456);
    probe_entry(64'h3C3C_0000_0000_0005, 8'd0, 7'd40, 0, 0);
  endtask

  task automatic test_bound_rules();
    logic [63:0] k;
    k = 64'h0123_4567_89AB_C003;
    store_entry(k, 8'd6, 7'd0, 100, dtt_pkg::BOUND_LOWER, 24'h0A0B0C);
    probe_entry(k, 8'd6, 7'd0, 0, 100);
    probe_entry(k, 8'd6, 7'd0, 0, 101);
    store_entry(k, 8'd6, 7'd0, 100, dtt_pkg::BOUND_UPPER, 24'h0A0B0C);
    probe_entry(k, 8'd6, 7'd0, 99, 0);
    store_entry(k, 8'd6, 7'd0, -29001, BOUND_NONE, 24'h000001);
    probe_entry(k, 8'd6, 7'd5, 32767, -32768);
    probe_entry(k, 8'd7, 7'd0, 0, 0);
  endtask

  task automatic test_replacement();
    logic [63:0] k_old;
    logic [63:0] k_new;
    k_old = 64'hDEAD_BEEF_0000_0004;
    k_new = 64'h1234_0000_0000_0004;
    store_entry(k_old, 8'd20, 7'd0, 500, dtt_pkg::BOUND_EXACT, 24'h111111);
    // Same key, shallower, same age: the entry must survive.
    store_entry(k_old, 8'd10, 7'd0, 600, dtt_pkg::BOUND_EXACT, 24'h222222);
    probe_entry(k_old, 8'd0, 7'd0, 0, 0);
    write_age(6'd63);
    store_entry(k_old, 8'd10, 7'd0, 700, dtt_pkg::BOUND_EXACT, 24'h333333);
    probe_entry(k_old, 8'd0, 7'd0, 0, 0);
    store_entry(k_new, 8'd0, 7'd0, -5, dtt_pkg::BOUND_LOWER, 24'h444444);
    probe_entry(k_old, 8'd0, 7'd0, 0, 0);
  endtask

  task automatic test_ignored_and_clear();
    send_item(make_item(MODE_IGNORED, 64'h1234_0000_0000_0004, 8'd127, 7'd0, 0, 0,
                        999, dtt_pkg::BOUND_EXACT, 24'h555555));
    probe_entry(64'h1234_0000_0000_0004, 8'd0, 7'd0, 0, -5);
    send_item(make_item(dtt_pkg::MODE_CLEAR, 64'd0, 8'd0, 7'd0, 0, 0, 16'sd0, BOUND_NONE,
                        24'd0));
    probe_entry(64'h1234_0000_0000_0004, 8'd0, 7'd0, 0, 0);
    probe_entry(64'd0, 8'd0, 7'd0, 0, 0);
  endtask

  // A few table indexes, each shared by several keys, so that probes match
  // often and stores collide.
  function automatic void fill_key_pool();
    logic [IDX_W-1:0] idx_set [6];
    idx_set[0] = '0;
    idx_set[1] = '1;
    for (int i = 2; i < 6; i++) idx_set[i] = IDX_W'($urandom_range(0, ENTRIES - 1));
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i]            = {$urandom, $urandom};
      key_pool[i][IDX_W-1:0] = idx_set[i % 6];
    end
    key_pool[0] = 64'd0;
  endfunction

  function automatic logic signed [15:0] random_score();
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      v = int'($urandom_range(0, 4000)) - 2000;
    end else if (roll < 80) begin
      v = $urandom_range(28990, 32768);
      if ($urandom_range(0, 1)) v = -v;
      else if (v == 32768) v = 32767;
    end else begin
      v = $urandom_range(0, 65535);
    end
    return v[15:0];
  endfunction

  function automatic dtt_pkg::item_t random_item();
    dtt_pkg::item_t it;
    int             roll;
    roll = $urandom_range(0, 999);
    if (roll < 470) it.mode = dtt_pkg::MODE_PROBE;
    else if (roll < 940) it.mode = dtt_pkg::MODE_STORE;
    else if (roll < 994) it.mode = MODE_IGNORED;
    else it.mode = dtt_pkg::MODE_CLEAR;
    if ($urandom_range(0, 99) < 85) begin
      it.position_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else begin
      it.position_key = {$urandom, $urandom};
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) it.search_depth = 8'($urandom_range(0, 12));
    else if (roll < 85) it.search_depth = 8'($urandom_range(0, 127));
    else it.search_depth = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 60) it.ply_from_root = 7'($urandom_range(0, 10));
    else it.ply_from_root = 7'($urandom_range(0, 127));
    it.window_low     = random_score();
    it.window_high    = random_score();
    it.store_score    = random_score();
    it.bound_kind     = 2'($urandom_range(0, 3));
    it.move_source    = 6'($urandom_range(0, 63));
    it.move_target    = 6'($urandom_range(0, 63));
    it.move_promo     = 4'($urandom_range(0, 15));
    it.move_flag_bits = 8'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    int             done;
    int             next_age_at;
    int             roll;
    logic [5:0]     age;
    dtt_pkg::item_t it;
    wait_idle();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    fill_key_pool();
    done        = 0;
    next_age_at = 0;
    while (done < n_items) begin
      if (done >= next_age_at) begin
        roll = $urandom_range(0, 3);
        case (roll)
          0:       age = 6'd0;
          1:       age = 6'd63;
          2:       age = age_model;
          default: age = 6'($urandom_range(0, 63));
        endcase
        write_age(age);
        next_age_at += AGE_PERIOD;
      end
      it = random_item();
      send_item(it);
      if (it.mode != MODE_IGNORED) done++;
    end
  endtask

  initial begin
    req_ch.valid          = 1'b0;
    req_ch.mode           = dtt_pkg::MODE_PROBE;
    req_ch.position_key   = 64'd0;
    req_ch.search_depth   = 8'd0;
    req_ch.ply_from_root  = 7'd0;
    req_ch.window_low     = 16'sd0;
    req_ch.window_high    = 16'sd0;
    req_ch.store_score    = 16'sd0;
    req_ch.bound_kind     = BOUND_NONE;
    req_ch.move_source    = 6'd0;
    req_ch.move_target    = 6'd0;
    req_ch.move_promo     = 4'd0;
    req_ch.move_flag_bits = 8'd0;
    send_idle_pct         = 24;
    recv_idle_pct         = 76;
    err_count             = 0;
    idle_cycles           = 0;
    results_checked       = 0;
    n_probes              = 0;
    n_stores              = 0;
    n_clears              = 0;
    n_ignored             = 0;
    n_matches             = 0;
    n_hits                = 0;
    n_age_writes          = 0;
    clear_table();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_entries();
    test_mate_and_saturation();
    test_bound_rules();
    test_replacement();
    test_ignored_and_clear();
    test_random(233, 24, 76);
    test_random(233, 76, 24);
    test_random(234, 0, 0);

    req_ch.valid <= 1'b0;
    while (probe_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d probes (%0d key matches, %0d cutoffs), %0d stores, %0d clears",
             n_probes, n_matches, n_hits, n_stores, n_clears);
    $display("and %0d ignored items; search age written %0d times, %0d results checked.",
             n_ignored, n_age_writes, results_checked);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
